>>> rtl/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg: deploy retry controller shared definitions
// Phase and outcome codes, opcode and register indexes, reset values and the
// on-time limiting function.
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

   // run phase of the controller
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_GAP  = 2'd2,
      PH_END  = 2'd3
   } phase_type;

   // reported run outcome
   typedef enum logic [2:0] {
      OC_IDLE     = 3'd0,
      OC_RETRYING = 3'd1,
      OC_DEPLOYED = 3'd2,
      OC_FAILED   = 3'd3,
      OC_ABORTED  = 3'd4
   } outcome_type;

   // request opcodes
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_ABORT = 1'b1;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TRIES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ON     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_INCR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_CEILING  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LEN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POLARITY    = 3'd5;

   // register reset values
   localparam logic [7:0]  RST_MAX_TRIES  = 8'd10;
   localparam logic [31:0] RST_BASE_ON    = 32'd5000;
   localparam logic [31:0] RST_ON_INCR    = 32'd5000;
   localparam logic [31:0] RST_ON_CEILING = 32'd60000;
   localparam logic [31:0] RST_GAP_LEN    = 32'd5000;
   localparam logic        RST_POLARITY   = 1'b0;

   // saturate a raw on-time to 32 bits and apply the effective ceiling
   function automatic logic [31:0] on_limit(input logic [40:0] raw,
                                            input logic [31:0] base,
                                            input logic [31:0] ceiling);
      logic [31:0] sat;
      logic [31:0] lim;
      sat = (|raw[40:32]) ? 32'hFFFF_FFFF : raw[31:0];
      lim = (ceiling != 32'd0 && ceiling < base) ? base : ceiling;
      return (lim != 32'd0 && sat > lim) ? lim : sat;
   endfunction

endpackage

`default_nettype wire

>>> rtl/deploy_retry_controller.sv
// ----------------------------------------------------------------------------
// deploy_retry_controller: heater-knife deployment retry controller
// Runs timed knife activations with growing on-time and observation gaps
// until the switch reports deployment, the run is aborted or tries run out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  req     | in        | req_valid/req_ready  | opcode, time, init flag, sense
//  rsp     | out       | rsp_valid/rsp_ready  | knife, outcome, tries, flags, on
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
//  one beat per cycle sustained while rsp is not stalled: a request lands in the
//  input register and is then evaluated by one pass through the transition logic
//  (one 8x32 multiply for the attempt on-time) into the response register.
//  the controller state registers are the response register, so a stalled
//  response holds the input register and back-pressures req.
//  synchronous active-high reset returns the configuration, state and valid registers to their defaults.
//
`default_nettype none

module deploy_retry_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_time_now_ms,
   input  wire logic        req_in_init_mode,
   input  wire logic        req_sense_level,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_knife_enable,
   output logic [2:0]       rsp_outcome,
   output logic [7:0]       rsp_tries_done,
   output logic             rsp_degraded_link,
   output logic             rsp_safe_mode_request,
   output logic [31:0]      rsp_active_on_ms,
   // register write port
   input  wire logic        csr_wr_en,
   input  wire logic [drc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0] csr_wdata
);

   // configuration registers
   logic [7:0]  max_tries_ff;
   logic [31:0] base_on_ff;
   logic [31:0] on_incr_ff;
   logic [31:0] on_ceiling_ff;
   logic [31:0] gap_len_ff;
   logic        polarity_ff;

   // input register
   logic        in_vld_ff;
   logic        in_op_ff;
   logic [31:0] in_now_ff;
   logic        in_init_ff;
   logic        in_sense_ff;

   // controller state, also the response register
   logic                 rsp_vld_ff;
   drc_pkg::phase_type   phase_ff,   phase_in;
   logic [31:0]          start_ff,   start_in;
   logic [7:0]           tries_ff,   tries_in;
   logic [31:0]          cur_on_ff,  cur_on_in;
   logic                 knife_ff,   knife_in;
   drc_pkg::outcome_type outcome_ff, outcome_in;
   logic                 degraded_ff, degraded_in;
   logic                 safe_ff,    safe_in;

   // datapath helpers
   logic        advance;
   logic        deployed;
   logic [31:0] elapsed;
   logic [7:0]  next_try;
   logic [7:0]  prior_tries;
   logic [39:0] incr_prod;
   logic [31:0] on_next;
   logic [31:0] on_second;
   logic        zero_all;

   // handshake: evaluate when the response register is free or draining
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_tries_ff  <= drc_pkg::RST_MAX_TRIES;
         base_on_ff    <= drc_pkg::RST_BASE_ON;
         on_incr_ff    <= drc_pkg::RST_ON_INCR;
         on_ceiling_ff <= drc_pkg::RST_ON_CEILING;
         gap_len_ff    <= drc_pkg::RST_GAP_LEN;
         polarity_ff   <= drc_pkg::RST_POLARITY;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            drc_pkg::CSR_MAX_TRIES:  max_tries_ff  <= csr_wdata[7:0];
            drc_pkg::CSR_BASE_ON:    base_on_ff    <= csr_wdata;
            drc_pkg::CSR_ON_INCR:    on_incr_ff    <= csr_wdata;
            drc_pkg::CSR_ON_CEILING: on_ceiling_ff <= csr_wdata;
            drc_pkg::CSR_GAP_LEN:    gap_len_ff    <= csr_wdata;
            drc_pkg::CSR_POLARITY:   polarity_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff    <= req_opcode;
         in_now_ff   <= req_time_now_ms;
         in_init_ff  <= req_in_init_mode;
         in_sense_ff <= req_sense_level;
      end
   end

   // on-time of the attempt that would start next, and of attempt two
   assign next_try    = 8'(tries_ff + 8'd1);
   assign prior_tries = (next_try == 8'd0) ? 8'd0 : tries_ff;
   assign incr_prod   = {32'd0, prior_tries} * {8'd0, on_incr_ff};
   assign on_next     = drc_pkg::on_limit({9'd0, base_on_ff} + {1'b0, incr_prod},
                                          base_on_ff, on_ceiling_ff);
   assign on_second   = drc_pkg::on_limit({9'd0, on_incr_ff}, base_on_ff,
                                          on_ceiling_ff);
   assign zero_all    = (base_on_ff == 32'd0) && (on_incr_ff == 32'd0);
   assign deployed    = (in_sense_ff == polarity_ff);
   assign elapsed     = in_now_ff - start_ff;

   // next state: all phase boundaries already passed within one beat
   always_comb begin : next_state
      logic        begin_run;
      logic        gap_run;
      logic [7:0]  gap_tries;
      logic [31:0] gap_next_on;

      phase_in    = phase_ff;
      start_in    = start_ff;
      tries_in    = tries_ff;
      cur_on_in   = cur_on_ff;
      knife_in    = knife_ff;
      outcome_in  = outcome_ff;
      degraded_in = degraded_ff;
      safe_in     = safe_ff;
      begin_run   = 1'b0;
      gap_run     = 1'b0;
      gap_tries   = tries_ff;
      gap_next_on = on_next;

      if (in_op_ff == drc_pkg::OP_ABORT) begin
         // abort keeps the phase start time
         if (phase_ff != drc_pkg::PH_END) begin
            knife_in    = 1'b0;
            outcome_in  = drc_pkg::OC_ABORTED;
            degraded_in = 1'b0;
            safe_in     = 1'b0;
            phase_in    = drc_pkg::PH_END;
         end
      end else begin
         // first boundary, using the real elapsed time
         unique case (phase_ff)
            drc_pkg::PH_IDLE: begin
               begin_run = in_init_ff;
            end
            drc_pkg::PH_ON: begin
               if (!in_init_ff) begin
                  knife_in    = 1'b0;
                  outcome_in  = drc_pkg::OC_ABORTED;
                  degraded_in = 1'b0;
                  safe_in     = 1'b0;
                  phase_in    = drc_pkg::PH_END;
                  start_in    = in_now_ff;
               end else if (deployed) begin
                  knife_in    = 1'b0;
                  outcome_in  = drc_pkg::OC_DEPLOYED;
                  degraded_in = 1'b0;
                  safe_in     = 1'b1;
                  phase_in    = drc_pkg::PH_END;
                  start_in    = in_now_ff;
               end else if (elapsed >= cur_on_ff) begin
                  knife_in    = 1'b0;
                  phase_in    = drc_pkg::PH_GAP;
                  start_in    = in_now_ff;
                  gap_run     = 1'b1;
                  gap_tries   = tries_ff;
                  gap_next_on = on_next;
               end
            end
            drc_pkg::PH_GAP: begin
               if (deployed) begin
                  knife_in    = 1'b0;
                  outcome_in  = drc_pkg::OC_DEPLOYED;
                  degraded_in = 1'b0;
                  safe_in     = 1'b1;
                  phase_in    = drc_pkg::PH_END;
                  start_in    = in_now_ff;
               end else if (elapsed >= gap_len_ff) begin
                  if (!in_init_ff) begin
                     knife_in    = 1'b0;
                     outcome_in  = drc_pkg::OC_ABORTED;
                     degraded_in = 1'b0;
                     safe_in     = 1'b0;
                     phase_in    = drc_pkg::PH_END;
                     start_in    = in_now_ff;
                  end else if (tries_ff >= max_tries_ff) begin
                     knife_in    = 1'b0;
                     outcome_in  = drc_pkg::OC_FAILED;
                     degraded_in = 1'b1;
                     safe_in     = 1'b1;
                     phase_in    = drc_pkg::PH_END;
                     start_in    = in_now_ff;
                  end else begin
                     begin_run = 1'b1;
                  end
               end
            end
            drc_pkg::PH_END: ;
            default: ;
         endcase

         // new attempt started at this beat's time
         if (begin_run) begin
            tries_in   = next_try;
            cur_on_in  = on_next;
            outcome_in = drc_pkg::OC_RETRYING;
            start_in   = in_now_ff;
            if (deployed) begin
               knife_in    = 1'b0;
               outcome_in  = drc_pkg::OC_DEPLOYED;
               degraded_in = 1'b0;
               safe_in     = 1'b1;
               phase_in    = drc_pkg::PH_END;
            end else if (on_next != 32'd0) begin
               knife_in = 1'b1;
               phase_in = drc_pkg::PH_ON;
            end else begin
               // zero on-time: straight into the gap
               knife_in    = 1'b0;
               phase_in    = drc_pkg::PH_GAP;
               gap_run     = 1'b1;
               gap_tries   = next_try;
               gap_next_on = zero_all ? 32'd0 : on_second;
            end
         end

         // gap entered at this beat's time and already over
         if (gap_run && gap_len_ff == 32'd0) begin
            if (gap_tries >= max_tries_ff) begin
               knife_in    = 1'b0;
               outcome_in  = drc_pkg::OC_FAILED;
               degraded_in = 1'b1;
               safe_in     = 1'b1;
               phase_in    = drc_pkg::PH_END;
               start_in    = in_now_ff;
            end else if (gap_next_on != 32'd0) begin
               tries_in   = 8'(gap_tries + 8'd1);
               cur_on_in  = gap_next_on;
               knife_in   = 1'b1;
               outcome_in = drc_pkg::OC_RETRYING;
               phase_in   = drc_pkg::PH_ON;
               start_in   = in_now_ff;
            end else begin
               // every on-time is zero: attempts run out within this beat
               tries_in    = max_tries_ff;
               cur_on_in   = 32'd0;
               knife_in    = 1'b0;
               outcome_in  = drc_pkg::OC_FAILED;
               degraded_in = 1'b1;
               safe_in     = 1'b1;
               phase_in    = drc_pkg::PH_END;
               start_in    = in_now_ff;
            end
         end
      end
   end

   // state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         phase_ff    <= drc_pkg::PH_IDLE;
         start_ff    <= 32'd0;
         tries_ff    <= 8'd0;
         cur_on_ff   <= 32'd0;
         knife_ff    <= 1'b0;
         outcome_ff  <= drc_pkg::OC_IDLE;
         degraded_ff <= 1'b0;
         safe_ff     <= 1'b0;
      end else begin
         if (advance) begin
            rsp_vld_ff  <= 1'b1;
            phase_ff    <= phase_in;
            start_ff    <= start_in;
            tries_ff    <= tries_in;
            cur_on_ff   <= cur_on_in;
            knife_ff    <= knife_in;
            outcome_ff  <= outcome_in;
            degraded_ff <= degraded_in;
            safe_ff     <= safe_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // response outputs
   assign rsp_valid             = rsp_vld_ff;
   assign rsp_knife_enable      = knife_ff;
   assign rsp_outcome           = outcome_ff;
   assign rsp_tries_done        = tries_ff;
   assign rsp_degraded_link     = degraded_ff;
   assign rsp_safe_mode_request = safe_ff;
   assign rsp_active_on_ms      = cur_on_ff;

endmodule

`default_nettype wire

>>> verif/deploy_retry_controller_tb.sv
// ----------------------------------------------------------------------------
// deploy_retry_controller_tb: deployment retry controller testbench
// Drives timed steps and abort commands through the request channel and checks
// every response beat field by field against an in-bench model of the knife
// run. Register settings change between phases of one long run that ends in a
// randomly picked way.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module deploy_retry_controller_tb;

   localparam int RUN_PHASES      = 6;
   localparam int STEPS_PER_PHASE = 240;
   localparam int REPORT_LIMIT    = 20;
   localparam int SETTLE_CYCLES   = 16;
   localparam int CHAIN_LIMIT     = 1024;
   localparam longint TIMEOUT_NS  = 2_000_000;

   // one request beat
   typedef struct packed {
      logic        op;
      logic [31:0] now;
      logic        init;
      logic        sense;
   } step_req_type;

   // controller state as seen through the response fields
   typedef struct packed {
      drc_pkg::phase_type   ph;
      logic [31:0]          start;
      logic [7:0]           tries;
      logic [31:0]          on_ms;
      logic                 knife;
      drc_pkg::outcome_type oc;
      logic                 degraded;
      logic                 safe;
   } knife_run_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [31:0] req_time_now_ms;
   logic        req_in_init_mode;
   logic        req_sense_level;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_knife_enable;
   logic [2:0]  rsp_outcome;
   logic [7:0]  rsp_tries_done;
   logic        rsp_degraded_link;
   logic        rsp_safe_mode_request;
   logic [31:0] rsp_active_on_ms;
   logic        csr_wr_en;
   logic [drc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   // register copy
   logic [7:0]  cfg_max_tries;
   logic [31:0] cfg_base;
   logic [31:0] cfg_incr;
   logic [31:0] cfg_ceiling;
   logic [31:0] cfg_gap;
   logic        cfg_polarity;

   step_req_type  pending_steps[$];
   knife_run_type expected_status[$];
   knife_run_type plan_run;
   knife_run_type check_run;
   knife_run_type want;
   step_req_type  next_req;
   logic [31:0] clock_ms;
   int          steps_left;
   logic        req_taken;
   logic        no_gaps;
   int          steps_accepted;
   int          responses_checked;
   int          mismatch_count;

   deploy_retry_controller i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_time_now_ms       (req_time_now_ms),
      .req_in_init_mode      (req_in_init_mode),
      .req_sense_level       (req_sense_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_knife_enable      (rsp_knife_enable),
      .rsp_outcome           (rsp_outcome),
      .rsp_tries_done        (rsp_tries_done),
      .rsp_degraded_link     (rsp_degraded_link),
      .rsp_safe_mode_request (rsp_safe_mode_request),
      .rsp_active_on_ms      (rsp_active_on_ms),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // clock
   always #4 clock = ~clock;

   // on-time of attempt n: saturate to 32 bits, then apply the effective cap
   function automatic logic [31:0] attempt_on_ms(input logic [7:0] n);
      logic [63:0] steps;
      logic [63:0] raw;
      logic [31:0] cap;
      steps = (n == 8'd0) ? 64'd0 : 64'(n - 8'd1);
      raw = 64'(cfg_base) + steps * 64'(cfg_incr);
      cap = (cfg_ceiling != 32'd0 && cfg_ceiling < cfg_base) ? cfg_base : cfg_ceiling;
      if (raw > 64'hFFFF_FFFF) raw = 64'hFFFF_FFFF;
      if (cap != 32'd0 && raw > 64'(cap)) raw = 64'(cap);
      return raw[31:0];
   endfunction

   function automatic knife_run_type run_at_reset();
      knife_run_type s;
      s = '0;
      s.ph = drc_pkg::PH_IDLE;
      s.oc = drc_pkg::OC_IDLE;
      return s;
   endfunction

   function automatic knife_run_type open_attempt(input knife_run_type s,
                                                  input logic [31:0] now);
      s.tries = s.tries + 8'd1;
      s.oc    = drc_pkg::OC_RETRYING;
      s.on_ms = attempt_on_ms(s.tries);
      s.ph    = drc_pkg::PH_ON;
      s.start = now;
      s.knife = 1'b1;
      return s;
   endfunction

   // terminal outcome: degraded only on failure, safe mode on failure or deployment
   function automatic knife_run_type close_run(input knife_run_type s,
                                               input drc_pkg::outcome_type oc,
                                               input logic [31:0] now);
      s.knife    = 1'b0;
      s.oc       = oc;
      s.degraded = (oc == drc_pkg::OC_FAILED);
      s.safe     = (oc == drc_pkg::OC_FAILED) || (oc == drc_pkg::OC_DEPLOYED);
      s.ph       = drc_pkg::PH_END;
      s.start    = now;
      return s;
   endfunction

   // state after one request beat; passed phase boundaries are crossed in turn
   function automatic knife_run_type next_run(input knife_run_type s, input step_req_type r);
      logic        busy;
      logic        seen;
      logic [31:0] el;
      int          k;
      seen = (r.sense == cfg_polarity);
      if (r.op == drc_pkg::OP_ABORT) begin
         if (s.ph != drc_pkg::PH_END) s = close_run(s, drc_pkg::OC_ABORTED, s.start);
      end else begin
         busy = 1'b1;
         for (k = 0; k < CHAIN_LIMIT && busy; k++) begin
            el = r.now - s.start;
            busy = 1'b0;
            case (s.ph)
               drc_pkg::PH_IDLE: begin
                  if (r.init) begin
                     s = open_attempt(s, r.now);
                     busy = 1'b1;
                  end
               end
               drc_pkg::PH_ON: begin
                  if (!r.init) s = close_run(s, drc_pkg::OC_ABORTED, r.now);
                  else if (seen) s = close_run(s, drc_pkg::OC_DEPLOYED, r.now);
                  else if (el >= s.on_ms) begin
                     s.knife = 1'b0;
                     s.ph    = drc_pkg::PH_GAP;
                     s.start = r.now;
                     busy    = 1'b1;
                  end
               end
               drc_pkg::PH_GAP: begin
                  if (seen) s = close_run(s, drc_pkg::OC_DEPLOYED, r.now);
                  else if (el >= cfg_gap) begin
                     if (!r.init) begin
                        s = close_run(s, drc_pkg::OC_ABORTED, r.now);
                     end else if (s.tries >= cfg_max_tries) begin
                        s = close_run(s, drc_pkg::OC_FAILED, r.now);
                     end else begin
                        s = open_attempt(s, r.now);
                        busy = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      return s;
   endfunction

   // time left before the planned run reaches its next phase boundary
   function automatic logic [31:0] phase_remaining();
      logic [31:0] span;
      logic [31:0] spent;
      span = (plan_run.ph == drc_pkg::PH_ON) ? plan_run.on_ms :
             (plan_run.ph == drc_pkg::PH_GAP) ? cfg_gap : 32'd0;
      spent = clock_ms - plan_run.start;
      return (spent < span) ? span - spent : 32'd0;
   endfunction

   task automatic report_error(input string msg);
      if (mismatch_count < REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want_v);
      if (got !== want_v)
         report_error($sformatf("response %0d %s is %0h, expected %0h",
                                responses_checked, name, got, want_v));
   endtask

   // queue one beat and advance the planning copy of the run
   task automatic queue_step(input logic op, input logic [31:0] t, input logic init,
                             input logic sense);
      step_req_type r;
      r.op    = op;
      r.now   = t;
      r.init  = init;
      r.sense = sense;
      pending_steps.push_back(r);
      plan_run = next_run(plan_run, r);
      clock_ms = t;
      if (steps_left > 0) steps_left--;
   endtask

   // well-formed run steps: mostly stay inside a phase or land right on its
   // boundary, spending attempts evenly over the remaining steps
   task automatic plan_steps(input int count);
      int          i;
      int          tries_left;
      int          odds;
      logic [31:0] remain;
      logic [31:0] adv;
      logic        init;
      for (i = 0; i < count; i++) begin
         remain = phase_remaining();
         tries_left = (plan_run.tries < cfg_max_tries) ?
                      int'(cfg_max_tries) - int'(plan_run.tries) : 0;
         odds = (steps_left > 0) ? tries_left * 2000 / steps_left : 1000;
         if (plan_run.ph == drc_pkg::PH_END || plan_run.ph == drc_pkg::PH_IDLE) begin
            queue_step(drc_pkg::OP_STEP, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
         end else if (tries_left > 0 && $urandom_range(0, 999) < odds) begin
            case ($urandom_range(0, 3))
               0, 1: adv = remain;
               2: adv = remain + $urandom_range(1, 16);
               default: adv = $urandom;
            endcase
            queue_step(drc_pkg::OP_STEP, clock_ms + adv, 1'b1, !cfg_polarity);
         end else begin
            if (remain <= 32'd1) adv = 32'd0;
            else if ($urandom_range(0, 2) == 0) adv = remain - 32'd1;
            else adv = $urandom_range(0, remain - 32'd1);
            // leaving init mode inside an unfinished gap must not abort
            init = !(plan_run.ph == drc_pkg::PH_GAP && remain != 32'd0 &&
                     $urandom_range(0, 4) == 0);
            queue_step(drc_pkg::OP_STEP, clock_ms + adv, init, !cfg_polarity);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_steps.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [drc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         drc_pkg::CSR_MAX_TRIES:  cfg_max_tries = value[7:0];
         drc_pkg::CSR_BASE_ON:    cfg_base      = value;
         drc_pkg::CSR_ON_INCR:    cfg_incr      = value;
         drc_pkg::CSR_ON_CEILING: cfg_ceiling   = value;
         drc_pkg::CSR_GAP_LEN:    cfg_gap       = value;
         drc_pkg::CSR_POLARITY:   cfg_polarity  = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] tries_cap, input logic [31:0] base,
                            input logic [31:0] incr, input logic [31:0] ceiling,
                            input logic [31:0] gap, input logic pol);
      write_reg(drc_pkg::CSR_MAX_TRIES, 32'(tries_cap));
      write_reg(drc_pkg::CSR_BASE_ON, base);
      write_reg(drc_pkg::CSR_ON_INCR, incr);
      write_reg(drc_pkg::CSR_ON_CEILING, ceiling);
      write_reg(drc_pkg::CSR_GAP_LEN, gap);
      write_reg(drc_pkg::CSR_POLARITY, 32'(pol));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver: a new beat only after the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_steps.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 9)) begin
            next_req = pending_steps.pop_front();
            req_valid        <= 1'b1;
            req_opcode       <= next_req.op;
            req_time_now_ms  <= next_req.now;
            req_in_init_mode <= next_req.init;
            req_sense_level  <= next_req.sense;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && (no_gaps || $urandom_range(0, 99) >= 9);
   end

   // monitor: predict on request beats, check on response beats
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         check_run = run_at_reset();
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            check_run = next_run(check_run, {req_opcode, req_time_now_ms,
                                             req_in_init_mode, req_sense_level});
            expected_status.push_back(check_run);
            steps_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               report_error("response beat with no request outstanding");
            end else begin
               want = expected_status.pop_front();
               compare_field("knife_enable", 32'(rsp_knife_enable), 32'(want.knife));
               compare_field("outcome", 32'(rsp_outcome), 32'(want.oc));
               compare_field("tries_done", 32'(rsp_tries_done), 32'(want.tries));
               compare_field("degraded_link", 32'(rsp_degraded_link), 32'(want.degraded));
               compare_field("safe_mode_request", 32'(rsp_safe_mode_request),
                             32'(want.safe));
               compare_field("active_on_ms", rsp_active_on_ms, want.on_ms);
               responses_checked++;
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      int          ph_i;
      int          k;
      int          ending;
      logic [31:0] base_pick;
      logic [31:0] t0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = drc_pkg::CSR_MAX_TRIES;
      csr_wdata = 32'd0;
      no_gaps = 1'b0;
      steps_left = 0;
      clock_ms = 32'd0;
      cfg_max_tries = drc_pkg::RST_MAX_TRIES;
      cfg_base = drc_pkg::RST_BASE_ON;
      cfg_incr = drc_pkg::RST_ON_INCR;
      cfg_ceiling = drc_pkg::RST_ON_CEILING;
      cfg_gap = drc_pkg::RST_GAP_LEN;
      cfg_polarity = drc_pkg::RST_POLARITY;
      plan_run = run_at_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle outside init mode, then two attempts at reset settings
      // starting just below the clock wrap
      t0 = 32'hFFFF_F000;
      queue_step(drc_pkg::OP_STEP, 32'd0, 1'b0, 1'b0);
      queue_step(drc_pkg::OP_STEP, 32'hFFFF_FFFF, 1'b0, 1'b1);
      queue_step(drc_pkg::OP_STEP, 32'h5A5A_5A5A, 1'b0, 1'b0);
      queue_step(drc_pkg::OP_STEP, t0, 1'b1, 1'b1);
      queue_step(drc_pkg::OP_STEP, t0 + 32'd4999, 1'b1, 1'b1);
      queue_step(drc_pkg::OP_STEP, t0 + 32'd5000, 1'b1, 1'b1);
      queue_step(drc_pkg::OP_STEP, t0 + 32'd9999, 1'b0, 1'b1);
      queue_step(drc_pkg::OP_STEP, t0 + 32'd10000, 1'b1, 1'b1);
      queue_step(drc_pkg::OP_STEP, t0 + 32'd25000, 1'b1, 1'b1);
      wait_drained();

      // random run through several register settings
      steps_left = RUN_PHASES * STEPS_PER_PHASE;
      for (ph_i = 0; ph_i < RUN_PHASES; ph_i++) begin
         case (ph_i)
            0: configure(8'd255, 32'd1, 32'd0, 32'd0, 32'd0, 1'b1);
            1: configure(8'd255, drc_pkg::RST_BASE_ON, drc_pkg::RST_ON_INCR,
                         drc_pkg::RST_ON_CEILING, drc_pkg::RST_GAP_LEN,
                         drc_pkg::RST_POLARITY);
            2: configure(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
            3: begin
               // nonzero ceiling below base
               base_pick = $urandom_range(2, 32'hFFFF_FFFF);
               configure(8'd255, base_pick, $urandom, $urandom_range(1, base_pick - 32'd1),
                         $urandom_range(0, 5000), 1'($urandom_range(0, 1)));
            end
            default: begin
               configure(8'd255, $urandom_range(1, 1000),
                         $urandom_range(0, 1) ? $urandom : $urandom_range(0, 500),
                         ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                         $urandom_range(0, 3000), 1'($urandom_range(0, 1)));
            end
         endcase
         no_gaps = (ph_i == 1);
         plan_steps(STEPS_PER_PHASE);
         wait_drained();
      end
      no_gaps = 1'b0;

      // end the run one way or another
      if (plan_run.ph == drc_pkg::PH_ON || plan_run.ph == drc_pkg::PH_GAP) begin
         ending = int'($urandom_range(0, 3));
         case (ending)
            0: queue_step(drc_pkg::OP_STEP, clock_ms + $urandom_range(0, 3), 1'b1,
                          cfg_polarity);
            1: queue_step(drc_pkg::OP_ABORT, $urandom, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            2: begin
               queue_step(drc_pkg::OP_STEP, clock_ms, 1'b0, !cfg_polarity);
               if (plan_run.ph != drc_pkg::PH_END)
                  queue_step(drc_pkg::OP_STEP, clock_ms + phase_remaining(), 1'b0,
                             !cfg_polarity);
            end
            default: begin
               write_reg(drc_pkg::CSR_MAX_TRIES, 32'd1);
               @(negedge clock);
               csr_wr_en <= 1'b0;
               for (k = 0; k < 4 && plan_run.ph != drc_pkg::PH_END; k++)
                  queue_step(drc_pkg::OP_STEP, clock_ms + phase_remaining(), 1'b1,
                             !cfg_polarity);
            end
         endcase
      end
      // after the end nothing may change any more
      for (k = 0; k < 24; k++)
         queue_step(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d responses for %0d request beats over %0d register settings",
               responses_checked, steps_accepted, RUN_PHASES + 1);
      $display("run reached %0d knife attempts and ended with outcome code %0d",
               check_run.tries, check_run.oc);
      if (mismatch_count == 0) begin
         $display("[deploy_retry_controller] OK");
      end else begin
         $display("[deploy_retry_controller] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d responses outstanding", expected_status.size());
      $display("[deploy_retry_controller] ERROR");
      $finish;
   end

endmodule
